@@ hdl/tpw_pkg.sv @@
// Shared types and constants for the two-level page walker.
package tpw_pkg;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned FRAME_W     = 20;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned OFS_W       = 12;
    localparam int unsigned PL_W        = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic MODE_REQ  = 1'b0;
    localparam logic MODE_RESP = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam int unsigned BIT_PRESENT  = 0;
    localparam int unsigned BIT_WRITABLE = 1;
    localparam int unsigned BIT_USER     = 2;

    typedef struct packed {
        logic               is_resp;
        logic [ADDR_W-1:0]  linear;
        logic               is_write;
        logic               user;
        logic [ADDR_W-1:0]  dir_addr;
        logic [FRAME_W-1:0] frame;
        logic               present;
        logic               writable;
        logic               user_ok;
    } t_entry;

endpackage

@@ hdl/tpw_if.sv @@
// Handshake channels of the page walker: request/response in, result out, config.
interface tpw_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] linear_address;
    logic        is_write;
    logic [1:0]  cpl;
    logic [31:0] read_data;

    modport source (output valid, mode, linear_address, is_write, cpl,
                    read_data, input ready);
    modport sink   (input valid, mode, linear_address, is_write, cpl,
                    read_data, output ready);
endinterface

interface tpw_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] read_address;
    logic [31:0] physical_address;
    logic        ok;

    modport source (output valid, kind, read_address, physical_address, ok,
                    input ready);
    modport sink   (input valid, kind, read_address, physical_address, ok,
                    output ready);
endinterface

interface tpw_cfg_if;
    logic        valid;
    logic        ready;
    logic [19:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ hdl/tpw_front.sv @@
// Front end: holds the directory base, accepts items and decodes them into queue entries.
module tpw_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tpw_cfg_if.sink         i_cfg,
    tpw_in_if.sink          i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output tpw_pkg::t_entry o_entry
);
    import tpw_pkg::*;

    logic [FRAME_W-1:0] r_dir_base;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_full;
    assign o_push      = i_in.valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_base <= '0;
        end else if (i_cfg.valid) begin
            r_dir_base <= i_cfg.data;
        end
    end

    always_comb begin
        o_entry          = '0;
        o_entry.is_resp  = (i_in.mode == MODE_RESP);
        o_entry.linear   = i_in.linear_address;
        o_entry.is_write = i_in.is_write;
        o_entry.user     = (i_in.cpl != '0);
        o_entry.dir_addr = {r_dir_base, i_in.linear_address[ADDR_W-1 -: IDX_W], 2'b00};
        o_entry.frame    = i_in.read_data[ADDR_W-1 -: FRAME_W];
        o_entry.present  = i_in.read_data[BIT_PRESENT];
        o_entry.writable = i_in.read_data[BIT_WRITABLE];
        o_entry.user_ok  = i_in.read_data[BIT_USER];
    end

endmodule

@@ hdl/tpw_queue.sv @@
// Small FIFO of decoded items between front and back end.
module tpw_queue #(
    parameter int unsigned DEPTH = tpw_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tpw_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tpw_pkg::t_entry o_entry
);
    import tpw_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               push_ok, pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

@@ hdl/tpw_back.sv @@
// Back end: walk state machine, entry checks and the registered result stage.
module tpw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  tpw_pkg::t_entry i_entry,
    output logic            o_pop,
    tpw_out_if.source       o_out
);
    import tpw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT_DIR,
        ST_WAIT_TBL
    } t_state;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_linear, n_linear;
    logic               r_write, n_write;
    logic               r_user, n_user;
    logic               r_out_valid, n_out_valid;
    logic               r_kind, n_kind;
    logic [ADDR_W-1:0]  r_raddr, n_raddr;
    logic [ADDR_W-1:0]  r_paddr, n_paddr;
    logic               r_ok, n_ok;
    logic               take;
    logic               allows;

    assign take  = i_q_valid && (!r_out_valid || o_out.ready);
    assign o_pop = take;

    assign o_out.valid            = r_out_valid;
    assign o_out.kind             = r_kind;
    assign o_out.read_address     = r_raddr;
    assign o_out.physical_address = r_paddr;
    assign o_out.ok               = r_ok;

    assign allows = i_entry.present &&
                    (!r_user || (i_entry.user_ok && (!r_write || i_entry.writable)));

    always_comb begin
        n_state     = r_state;
        n_linear    = r_linear;
        n_write     = r_write;
        n_user      = r_user;
        n_out_valid = r_out_valid && !o_out.ready;
        n_kind      = r_kind;
        n_raddr     = r_raddr;
        n_paddr     = r_paddr;
        n_ok        = r_ok;
        if (take) begin
            case (r_state)
                ST_WAIT_DIR, ST_WAIT_TBL: begin
                    if (i_entry.is_resp) begin
                        n_out_valid = 1'b1;
                        n_raddr     = '0;
                        n_paddr     = '0;
                        n_ok        = 1'b0;
                        if (!allows) begin
                            n_state = ST_IDLE;
                            n_kind  = KIND_DONE;
                        end else if (r_state == ST_WAIT_DIR) begin
                            n_state = ST_WAIT_TBL;
                            n_kind  = KIND_READ;
                            n_raddr = {i_entry.frame, r_linear[OFS_W +: IDX_W], 2'b00};
                        end else begin
                            n_state = ST_IDLE;
                            n_kind  = KIND_DONE;
                            n_paddr = {i_entry.frame, r_linear[OFS_W-1:0]};
                            n_ok    = 1'b1;
                        end
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                    if (!i_entry.is_resp) begin
                        n_state     = ST_WAIT_DIR;
                        n_linear    = i_entry.linear;
                        n_write     = i_entry.is_write;
                        n_user      = i_entry.user;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_READ;
                        n_raddr     = i_entry.dir_addr;
                        n_paddr     = '0;
                        n_ok        = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_linear    <= '0;
            r_write     <= 1'b0;
            r_user      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_linear    <= n_linear;
            r_write     <= n_write;
            r_user      <= n_user;
            r_out_valid <= n_out_valid;
        end
        r_kind  <= n_kind;
        r_raddr <= n_raddr;
        r_paddr <= n_paddr;
        r_ok    <= n_ok;
    end

endmodule

@@ hdl/two_level_page_walker.sv @@
// Top level of the two-level page walker.
// Usage:
//   i_in carries one item per handshake: mode 0 is a translation request
//   (linear address, write flag, privilege level), mode 1 is an entry word
//   returning from memory. o_out carries results: kind 0 asks memory to read
//   the entry at read_address, kind 1 ends a walk with physical_address and
//   ok (0 means page fault). The caller answers each kind 0 result with a
//   mode 1 item. i_cfg writes the page directory frame number; write it
//   only while no walk is in flight.
//   Requests seen while a walk is busy, and responses seen while idle, are
//   dropped without a result.
// Timing: an item is registered in the item queue, then in the result register
//   before its result shows on o_out. One item is accepted per cycle while the
//   queue has room; the back end retires one item a cycle unless o_out stalls.
// Reset: synchronous, active low; clears the walk state, the queue and the
//   directory base (to 0).
// Stall: when o_out is not taken, the result register holds, the back end
//   stops, and i_in keeps accepting until the queue of QUEUE_DEPTH items fills.
module two_level_page_walker #(
    parameter int unsigned QUEUE_DEPTH = tpw_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpw_cfg_if.sink   i_cfg,
    tpw_in_if.sink    i_in,
    tpw_out_if.source o_out
);
    import tpw_pkg::*;

    logic   q_full;
    logic   q_push;
    logic   q_valid;
    logic   q_pop;
    t_entry front_entry;
    t_entry back_entry;

    tpw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (front_entry)
    );

    tpw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (back_entry)
    );

    tpw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_entry   (back_entry),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule
